### rtl/core/lpbp_pkg.sv
// shared types, constants and codes for the led progress bar and pulse core
package lpbp_pkg;

  localparam int LED_COUNT_DEF   = 8;
  localparam int PULSE_STEPS_DEF = 400;

  localparam int Q16_W     = 17;
  localparam int FILL_W    = 23;
  localparam int LED_W     = 6;
  localparam int COLOR_W   = 24;
  localparam int INT_W     = 9;
  localparam int CH_W      = 8;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [Q16_W-1:0] FULL_Q16   = 17'd65536;
  localparam logic [Q16_W-1:0] HALF_Q16   = 17'd32768;
  localparam logic [10:0]      SMOOTH_Q16 = 11'd1311;
  localparam logic [INT_W-1:0] INT_FULL   = 9'd256;

  localparam logic [MODE_W-1:0] MODE_BAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BAR_COLOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREATH_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY    = 2'd2;

  localparam logic [COLOR_W-1:0] BAR_COLOR_RST    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] BREATH_COLOR_RST = 24'h000000;
  localparam logic [INT_W-1:0]   INTENSITY_RST    = 9'd256;

  // element 2 green, 1 red, 0 blue
  typedef logic [2:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    rgb_t             bar_color;
    rgb_t             breath_color;
    logic [INT_W-1:0] intensity;
  } cfg_t;

  typedef struct packed {
    logic              pulse;
    logic              raise;
    logic [FILL_W-1:0] fill;
    rgb_t              pch;
  } frame_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_STEP,
    F_APPLY,
    F_AREA,
    F_PREP,
    F_DIV,
    F_PMUL,
    F_PREC,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHAN,
    B_OUT
  } back_state_t;

endpackage

### rtl/core/led_progress_bar_with_pulse_core.sv
// top level of the led progress bar and breathing light core
//
//   channel | direction | handshake        | payload
//   in      | input     | in_push/in_full  | in_mode, in_goal_progress
//   out     | output    | out_pop/out_empty| led position, green, red, blue, last flag
//   cfg     | input     | cfg_we           | cfg_index, cfg_data
//
// front end states: bar tick step, apply, push; clear tick step, push; pulsing tick
// step, area, prep, the 8 step serial divider for the breathing level, pmul, prec,
// push; back end: idle pops a frame, then each led takes a chan and an out state on
// one shared channel stage; neither end takes a new tick before the last is through
// a two entry frame queue lets the front run ahead; out_pop stalls the back, and the
// front once the queue is full; synchronous active low reset, no clearing pass
module led_progress_bar_with_pulse_core import lpbp_pkg::*; #(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int PULSE_STEPS = PULSE_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [Q16_W-1:0]     in_goal_progress,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [LED_W-1:0]     out_led_pos,
  output logic [CH_W-1:0]      out_green_level,
  output logic [CH_W-1:0]      out_red_level,
  output logic [CH_W-1:0]      out_blue_level,
  output logic                 out_last_led,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  cfg_t   cfg_r;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  frame_t q_wr;
  frame_t q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bar_color    <= BAR_COLOR_RST;
      cfg_r.breath_color <= BREATH_COLOR_RST;
      cfg_r.intensity    <= INTENSITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAR_COLOR:    cfg_r.bar_color    <= cfg_data;
        REG_BREATH_COLOR: cfg_r.breath_color <= cfg_data;
        REG_INTENSITY:    cfg_r.intensity    <= cfg_data[INT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpbp_front #(
    .LED_COUNT   (LED_COUNT),
    .PULSE_STEPS (PULSE_STEPS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_goal_progress (in_goal_progress),
    .cfg              (cfg_r),
    .q_push           (q_push),
    .q_data           (q_wr),
    .q_full           (q_full)
  );

  lpbp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  lpbp_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_rd),
    .q_pop           (q_pop),
    .cfg             (cfg_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_led_pos     (out_led_pos),
    .out_green_level (out_green_level),
    .out_red_level   (out_red_level),
    .out_blue_level  (out_blue_level),
    .out_last_led    (out_last_led)
  );

endmodule

### rtl/core/lpbp_front.sv
// front end: takes a tick, updates progress and phase, works out the pulse color
module lpbp_front import lpbp_pkg::*; #(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int PULSE_STEPS = PULSE_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [Q16_W-1:0]  in_goal_progress,
  input  cfg_t              cfg,
  output logic              q_push,
  output frame_t            q_data,
  input  logic              q_full
);

  localparam int PH_W  = $clog2(PULSE_STEPS);
  localparam int U_W   = 10;
  localparam int D_W   = 21;
  localparam int NUM_W = 22;
  localparam int DIV_W = 31;
  localparam logic [D_W-1:0]  D_BASE  = D_W'(5 * PULSE_STEPS * PULSE_STEPS);
  localparam logic [U_W-1:0]  S_U     = U_W'(PULSE_STEPS);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PULSE_STEPS - 1);
  localparam logic [6:0]      LED_N   = 7'(LED_COUNT);

  front_state_t         state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [Q16_W-1:0]     goal_r;
  logic [Q16_W-1:0]     smoothed_r;
  logic [PH_W-1:0]      phase_r;
  logic                 up_r;
  logic [10:0]          step_r;
  logic [16:0]          a_r;
  logic                 neg_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dsh_r;
  logic [CH_W-1:0]      quo_r;
  logic [2:0]           cnt_r;
  logic [2:0][15:0]     y_r;
  rgb_t                 pch_r;

  logic [Q16_W-1:0]     goal_clamp;
  logic                 up;
  logic [Q16_W-1:0]     mag;
  logic [27:0]          prod;
  logic [10:0]          step;
  logic [Q16_W:0]       nv;
  logic [Q16_W-1:0]     applied;
  logic [U_W-1:0]       u2;
  logic                 u_ge;
  logic [U_W-1:0]       u;
  logic [19:0]          area;
  logic [D_W-1:0]       n_v;
  logic [D_W-1:0]       d_v;
  logic [NUM_W-1:0]     num;
  logic [DIV_W-1:0]     dividend;
  logic [DIV_W-1:0]     divisor;
  logic                 div_ge;
  logic [2:0][15:0]     y_v;
  logic [2:0][23:0]     recip;
  logic [2:0][CH_W-1:0] q0;
  logic [2:0][15:0]     rmd;
  rgb_t                 pch_v;

  assign goal_clamp = (in_goal_progress > FULL_Q16) ? FULL_Q16 : in_goal_progress;

  // smoothing step
  assign up   = goal_r >= smoothed_r;
  assign mag  = up ? (goal_r - smoothed_r) : (smoothed_r - goal_r);
  assign prod = {11'd0, mag} * {17'd0, SMOOTH_Q16} + 28'd32768;
  assign step = (prod[27:16] == 12'd0 && mag != '0) ? 11'd1 : prod[26:16];
  assign nv   = {1'b0, smoothed_r} + 18'(step_r);

  always_comb begin
    if (up_r) begin
      applied = (nv > {1'b0, FULL_Q16}) ? FULL_Q16 : nv[Q16_W-1:0];
    end else begin
      applied = (17'(step_r) > smoothed_r) ? '0 : smoothed_r - 17'(step_r);
    end
  end

  // breathing level, rational sine over each half wave
  assign u2   = U_W'(phase_r) << 1;
  assign u_ge = u2 >= S_U;
  assign u    = u_ge ? (u2 - S_U) : u2;
  assign area = {10'd0, u} * {10'd0, S_U - u};

  assign n_v      = D_W'({a_r, 4'b0});
  assign d_v      = D_BASE - D_W'({a_r, 2'b0});
  assign num      = neg_r ? ({1'b0, d_v} - {1'b0, n_v}) : ({1'b0, d_v} + {1'b0, n_v});
  assign dividend = DIV_W'({num, 8'b0}) - DIV_W'(num) + DIV_W'(d_v);
  assign divisor  = DIV_W'({d_v, 8'b0});
  assign div_ge   = rem_r >= dsh_r;

  // pulse color: round(c * level / 255) per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      y_v[k]   = 16'({8'd0, cfg.breath_color[k]} * {8'd0, quo_r} + 16'd127);
      recip[k] = 24'({y_r[k], 8'b0}) + 24'(y_r[k]);
      q0[k]    = recip[k][23:16];
      rmd[k]   = y_r[k] - (16'({q0[k], 8'b0}) - 16'(q0[k]));
      pch_v[k] = (rmd[k] >= 16'd255) ? q0[k] + 8'd1 : q0[k];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_push) state_nxt = F_STEP;
      end
      F_STEP: begin
        if (mode_r == MODE_BAR) state_nxt = F_APPLY;
        else if (mode_r == MODE_PULSE) state_nxt = F_AREA;
        else state_nxt = F_PUSH;
      end
      F_APPLY: state_nxt = F_PUSH;
      F_AREA:  state_nxt = F_PREP;
      F_PREP:  state_nxt = F_DIV;
      F_DIV: begin
        if (cnt_r == 3'd7) state_nxt = F_PMUL;
      end
      F_PMUL:  state_nxt = F_PREC;
      F_PREC:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
    endcase
  end

  always_comb begin
    in_full = state_r != F_IDLE;
    q_push  = (state_r == F_PUSH) && !q_full;
    q_data.pulse = mode_r == MODE_PULSE;
    q_data.raise = (mode_r == MODE_BAR) && (goal_r != '0);
    q_data.fill  = {6'd0, smoothed_r} * {16'd0, LED_N};
    q_data.pch   = pch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      smoothed_r <= '0;
      phase_r    <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        F_IDLE: begin
          if (in_push) begin
            mode_r <= in_mode;
            goal_r <= goal_clamp;
          end
        end
        F_STEP: begin
          if (mode_r == MODE_BAR) begin
            up_r   <= up;
            step_r <= step;
          end else if (mode_r == MODE_PULSE) begin
            smoothed_r <= FULL_Q16;
            phase_r    <= (phase_r == PH_LAST) ? '0 : phase_r + 1'b1;
          end else begin
            smoothed_r <= '0;
            phase_r    <= '0;
          end
        end
        F_APPLY: begin
          smoothed_r <= applied;
          phase_r    <= '0;
        end
        F_AREA: begin
          a_r   <= area[16:0];
          neg_r <= u_ge;
        end
        F_PREP: begin
          rem_r <= dividend;
          dsh_r <= divisor;
          quo_r <= '0;
          cnt_r <= '0;
        end
        F_DIV: begin
          rem_r <= div_ge ? rem_r - dsh_r : rem_r;
          dsh_r <= dsh_r >> 1;
          quo_r <= {quo_r[CH_W-2:0], div_ge};
          cnt_r <= cnt_r + 3'd1;
        end
        F_PMUL: y_r   <= y_v;
        F_PREC: pch_r <= pch_v;
        F_PUSH: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
    smoothed_r <= FULL_Q16)
    else $error("smoothed progress above full");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_LAST)
    else $error("pulse phase out of range");
`endif

endmodule

### rtl/core/lpbp_fifo.sv
// short frame queue between front end and back end
module lpbp_fifo import lpbp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t wr_data,
  output logic   full,
  input  logic   pop,
  output frame_t rd_data,
  output logic   empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("frame queue read while empty");
`endif

endmodule

### rtl/core/lpbp_back.sv
// back end: per led brightness, channel scaling and the output register
module lpbp_back import lpbp_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  frame_t           q_data,
  output logic             q_pop,
  input  cfg_t             cfg,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [LED_W-1:0] out_led_pos,
  output logic [CH_W-1:0]  out_green_level,
  output logic [CH_W-1:0]  out_red_level,
  output logic [CH_W-1:0]  out_blue_level,
  output logic             out_last_led
);

  localparam logic [LED_W-1:0] LAST = LED_W'(LED_COUNT - 1);

  back_state_t      state_r, state_nxt;
  frame_t           fr_r;
  logic [LED_W-1:0] led_r;
  logic [Q16_W-1:0] b_r;
  rgb_t             gch_r;
  logic             out_v_r;
  logic [LED_W-1:0] out_idx_r;
  rgb_t             out_ch_r;
  logic             out_last_r;

  logic             out_load;
  logic             at_last;
  logic [INT_W-1:0] isat;
  logic [2:0][23:0] bar_prod;
  rgb_t             gch_v;
  logic [2:0][16:0] sc_prod;
  rgb_t             sc_v;

  function automatic logic [Q16_W-1:0] bright(input logic [FILL_W-1:0] fill,
                                              input logic [LED_W:0] idx,
                                              input logic raise);
    logic [FILL_W-1:0] base;
    logic [FILL_W-1:0] diff;
    logic [Q16_W-1:0]  b;
    base = {idx, 16'b0};
    diff = fill - base;
    if (fill <= base) b = '0;
    else if (diff > FILL_W'(FULL_Q16)) b = FULL_Q16;
    else b = diff[Q16_W-1:0];
    if (idx == '0 && raise && b < HALF_Q16) b = HALF_Q16;
    return b;
  endfunction

  assign isat     = (cfg.intensity > INT_FULL) ? INT_FULL : cfg.intensity;
  assign at_last  = led_r == LAST;
  assign out_load = (state_r == B_OUT) && (!out_v_r || out_pop);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bar_prod[k] = {16'd0, cfg.bar_color[k]} * {7'd0, b_r};
      gch_v[k]    = fr_r.pulse ? fr_r.pch[k] : bar_prod[k][23:16];
      sc_prod[k]  = {9'd0, gch_r[k]} * {8'd0, isat};
      sc_v[k]     = sc_prod[k][15:8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = B_CHAN;
      end
      B_CHAN: state_nxt = B_OUT;
      B_OUT: begin
        if (out_load) state_nxt = at_last ? B_IDLE : B_CHAN;
      end
    endcase
  end

  always_comb begin
    q_pop           = (state_r == B_IDLE) && !q_empty;
    out_empty       = !out_v_r;
    out_led_pos     = out_idx_r;
    out_green_level = out_ch_r[2];
    out_red_level   = out_ch_r[1];
    out_blue_level  = out_ch_r[0];
    out_last_led    = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_v_r <= 1'b1;
      else if (out_pop) out_v_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            fr_r  <= q_data;
            led_r <= '0;
            b_r   <= bright(q_data.fill, '0, q_data.raise);
          end
        end
        B_CHAN: begin
          gch_r <= gch_v;
          b_r   <= bright(fr_r.fill, {1'b0, led_r} + 1'b1, fr_r.raise);
        end
        B_OUT: begin
          if (out_load) begin
            out_idx_r  <= led_r;
            out_ch_r   <= sc_v;
            out_last_r <= at_last;
            if (!at_last) led_r <= led_r + 1'b1;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_last_r) |-> (out_idx_r == LAST))
    else $error("last led flag on wrong index");

  a_pop_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == B_CHAN && led_r == '0))
    else $error("frame not started at led zero");
`endif

endmodule
